### src/cpws_pkg.sv
package cpws_pkg;

  // Default sample window and internal queue size
  localparam int CAPTURE_DEPTH_DEF = 16384;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int WIDTH_W = 13;
  localparam int COUNT_W = 10;
  localparam int TOTAL_W = 23;
  localparam int SKIP_W = 4;
  localparam int INDEX_W = 14;

  localparam logic [WIDTH_W-1:0] WIDTH_ONES = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONES = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_ONES = '1;

  // Register map
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_MAX_WIDTH = 2'd0;
  localparam logic [1:0] REG_MAX_TRANSITIONS = 2'd1;
  localparam logic [1:0] REG_SKIP_PULSES = 2'd2;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST = 13'd5000;
  localparam logic [COUNT_W-1:0] MAX_TRANSITIONS_RST = 10'd500;
  localparam logic [SKIP_W-1:0] SKIP_PULSES_RST = 4'd4;

  typedef struct packed {
    logic scl_level;
    logic end_of_capture;
  } in_item_t;

  typedef struct packed {
    logic edge_found;
    logic [INDEX_W-1:0] first_edge_index;
    logic [COUNT_W-1:0] high_count;
    logic [TOTAL_W-1:0] high_total;
    logic [WIDTH_W-1:0] high_min;
    logic [WIDTH_W-1:0] high_max;
    logic [COUNT_W-1:0] low_count;
    logic [TOTAL_W-1:0] low_total;
    logic [WIDTH_W-1:0] low_min;
    logic [WIDTH_W-1:0] low_max;
  } out_item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] max_width;
    logic [COUNT_W-1:0] max_transitions;
    logic [SKIP_W-1:0] skip_pulses;
  } cfg_t;

  // One entry of the front-to-back queue: a closed pulse, a report, or both
  typedef struct packed {
    logic pulse_valid;
    logic pulse_high;
    logic [WIDTH_W-1:0] width;
    logic report;
    logic edge_found;
    logic [INDEX_W-1:0] edge_index;
  } token_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [WIDTH_W-1:0] min;
    logic [WIDTH_W-1:0] max;
  } stats_t;

  localparam stats_t STATS_RESET = '{count: '0, total: '0, min: WIDTH_ONES, max: '0};

endpackage

### src/cpws_regs.sv
module cpws_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cpws_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output cpws_pkg::cfg_t                    cfg
);

  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_width       <= cpws_pkg::MAX_WIDTH_RST;
      cfg.max_transitions <= cpws_pkg::MAX_TRANSITIONS_RST;
      cfg.skip_pulses     <= cpws_pkg::SKIP_PULSES_RST;
    end else if (wr_en) begin
      case (reg_sel)
        cpws_pkg::REG_MAX_WIDTH: begin
          cfg.max_width <= pwdata[cpws_pkg::WIDTH_W-1:0];
        end
        cpws_pkg::REG_MAX_TRANSITIONS: begin
          cfg.max_transitions <= pwdata[cpws_pkg::COUNT_W-1:0];
        end
        cpws_pkg::REG_SKIP_PULSES: begin
          cfg.skip_pulses <= pwdata[cpws_pkg::SKIP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cpws_pkg::REG_MAX_WIDTH:       prdata = 32'(cfg.max_width);
      cpws_pkg::REG_MAX_TRANSITIONS: prdata = 32'(cfg.max_transitions);
      cpws_pkg::REG_SKIP_PULSES:     prdata = 32'(cfg.skip_pulses);
      default:                       prdata = '0;
    endcase
  end

endmodule

### src/cpws_front.sv
module cpws_front #(
  parameter int CAPTURE_DEPTH = cpws_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  cpws_pkg::in_item_t   item,
  input  cpws_pkg::cfg_t       cfg,
  output logic                 push,
  output cpws_pkg::token_t     token
);

  localparam int IW = $clog2(CAPTURE_DEPTH);
  localparam int EW = IW + cpws_pkg::INDEX_W;
  localparam logic [IW-1:0] LAST_INDEX = IW'(CAPTURE_DEPTH - 1);

  logic                         have_previous, have_previous_next;
  logic                         previous_level, previous_level_next;
  logic                         measuring, measuring_next;
  logic [IW-1:0]                sample_index, sample_index_next;
  logic [IW-1:0]                edge_index, edge_index_next;
  logic [cpws_pkg::WIDTH_W-1:0] width_counter, width_counter_next;
  logic [cpws_pkg::COUNT_W-1:0] edge_counter, edge_counter_next;

  logic                         active;
  logic                         start;
  logic                         meas_now;
  logic                         counting;
  logic                         level_change;
  logic [cpws_pkg::WIDTH_W-1:0] width_base;
  logic [EW-1:0]                edge_index_ext;

  always_comb begin
    active       = sample_index < LAST_INDEX;
    start        = !measuring && have_previous && previous_level && !item.scl_level;
    meas_now     = measuring | start;
    counting     = active && meas_now && (edge_counter < cfg.max_transitions);
    level_change = item.scl_level != previous_level;
    width_base   = start ? '0 : width_counter;

    have_previous_next  = have_previous;
    previous_level_next = previous_level;
    measuring_next      = measuring;
    sample_index_next   = sample_index;
    edge_index_next     = edge_index;
    width_counter_next  = width_counter;
    edge_counter_next   = edge_counter;

    token             = '0;
    token.pulse_high  = previous_level;
    token.width       = width_base;
    token.report      = item.end_of_capture;

    if (active) begin
      measuring_next      = meas_now;
      have_previous_next  = 1'b1;
      previous_level_next = item.scl_level;
      sample_index_next   = sample_index + 1'b1;
      width_counter_next  = width_base;
      if (start) begin
        edge_index_next = sample_index;
      end
      if (counting) begin
        if (level_change) begin
          edge_counter_next = edge_counter + 1'b1;
          // a zero width only arises on the opening edge; it closes nothing
          token.pulse_valid = width_base != '0;
          width_counter_next = '0;
        end
        if (width_counter_next != cpws_pkg::WIDTH_ONES) begin
          width_counter_next = width_counter_next + 1'b1;
        end
      end
    end

    edge_index_ext   = EW'(edge_index_next);
    token.edge_found = measuring_next;
    token.edge_index = measuring_next ? edge_index_ext[cpws_pkg::INDEX_W-1:0] : '0;

    push = accept && (token.pulse_valid || item.end_of_capture);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous  <= 1'b0;
      previous_level <= 1'b0;
      measuring      <= 1'b0;
      sample_index   <= '0;
      edge_index     <= '0;
      width_counter  <= '0;
      edge_counter   <= '0;
    end else if (accept) begin
      if (item.end_of_capture) begin
        have_previous  <= 1'b0;
        previous_level <= 1'b0;
        measuring      <= 1'b0;
        sample_index   <= '0;
        edge_index     <= '0;
        width_counter  <= '0;
        edge_counter   <= '0;
      end else begin
        have_previous  <= have_previous_next;
        previous_level <= previous_level_next;
        measuring      <= measuring_next;
        sample_index   <= sample_index_next;
        edge_index     <= edge_index_next;
        width_counter  <= width_counter_next;
        edge_counter   <= edge_counter_next;
      end
    end
  end

endmodule

### src/cpws_queue.sv
module cpws_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cpws_pkg::token_t   push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output cpws_pkg::token_t   head
);

  localparam int AW = cpws_pkg::QUEUE_AW;

  cpws_pkg::token_t entries [cpws_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full      = count == (AW + 1)'(cpws_pkg::QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/cpws_back.sv
module cpws_back (
  input  logic                clk,
  input  logic                rst,
  input  cpws_pkg::cfg_t      cfg,
  input  logic                tok_valid,
  input  cpws_pkg::token_t    tok,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output cpws_pkg::out_item_t out_data
);

  cpws_pkg::stats_t            high_stats, high_stats_next;
  cpws_pkg::stats_t            low_stats, low_stats_next;
  logic [cpws_pkg::SKIP_W-1:0] high_seen, high_seen_next;
  logic [cpws_pkg::SKIP_W-1:0] low_seen, low_seen_next;
  cpws_pkg::out_item_t         result;

  function automatic cpws_pkg::stats_t add_pulse(cpws_pkg::stats_t s,
                                                 logic [cpws_pkg::WIDTH_W-1:0] w);
    cpws_pkg::stats_t            r;
    logic [cpws_pkg::TOTAL_W:0]  sum;
    r   = s;
    sum = (cpws_pkg::TOTAL_W + 1)'(s.total) + (cpws_pkg::TOTAL_W + 1)'(w);
    if (s.count != cpws_pkg::COUNT_ONES) begin
      r.count = s.count + 1'b1;
    end
    r.total = sum[cpws_pkg::TOTAL_W] ? cpws_pkg::TOTAL_ONES : sum[cpws_pkg::TOTAL_W-1:0];
    if (w < s.min) begin
      r.min = w;
    end
    if (w > s.max) begin
      r.max = w;
    end
    return r;
  endfunction

  // a report needs the output register free; a plain pulse never waits
  assign pop = tok_valid && (!tok.report || !out_valid || out_ready);

  always_comb begin
    high_stats_next = high_stats;
    low_stats_next  = low_stats;
    high_seen_next  = high_seen;
    low_seen_next   = low_seen;
    if (tok.pulse_valid) begin
      if (tok.pulse_high) begin
        if (high_seen < cfg.skip_pulses) begin
          high_seen_next = high_seen + 1'b1;
        end else if (tok.width < cfg.max_width) begin
          high_stats_next = add_pulse(high_stats, tok.width);
        end
      end else begin
        if (low_seen < cfg.skip_pulses) begin
          low_seen_next = low_seen + 1'b1;
        end else if (tok.width < cfg.max_width) begin
          low_stats_next = add_pulse(low_stats, tok.width);
        end
      end
    end

    result.edge_found       = tok.edge_found;
    result.first_edge_index = tok.edge_index;
    result.high_count       = high_stats_next.count;
    result.high_total       = high_stats_next.total;
    result.high_min         = high_stats_next.min;
    result.high_max         = high_stats_next.max;
    result.low_count        = low_stats_next.count;
    result.low_total        = low_stats_next.total;
    result.low_min          = low_stats_next.min;
    result.low_max          = low_stats_next.max;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_stats <= cpws_pkg::STATS_RESET;
      low_stats  <= cpws_pkg::STATS_RESET;
      high_seen  <= '0;
      low_seen   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        if (tok.report) begin
          high_stats <= cpws_pkg::STATS_RESET;
          low_stats  <= cpws_pkg::STATS_RESET;
          high_seen  <= '0;
          low_seen   <= '0;
        end else begin
          high_stats <= high_stats_next;
          low_stats  <= low_stats_next;
          high_seen  <= high_seen_next;
          low_seen   <= low_seen_next;
        end
      end
      if (pop && tok.report) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && tok.report) begin
      out_data <= result;
    end
  end

endmodule

### src/clock_pulse_width_statistics_unit.sv
// Clock pulse width statistics.
// Input channel (in_valid/in_ready/in_data): one sampled clock-line level per
// transaction. The first high-to-low edge opens measurement; each following
// high and low pulse is timed in samples; unless skipped or too wide, it is
// folded into per-level count, saturating total, minimum and maximum. The
// end_of_capture transaction produces exactly one report on the output
// channel (out_valid/out_ready/out_data) and clears the measurement state.
// Configuration: APB-style port, max_width at 0x0, max_transitions at 0x4,
// skip_pulses at 0x8; pready is tied high. Write only while idle.
// Throughput: one sample per cycle while the queue has room. The front end
// times pulses and pushes closed pulses and reports into a 4-entry queue;
// the back end folds one queue entry per cycle into the statistics.
// Report path: the end_of_capture transaction is pushed into the queue, and
// the back end pops it and registers the report onto out_valid/out_data.
// Stalls: while out_ready is low a pending report holds the back end; the
// queue keeps taking samples until it is full, then in_ready drops.
// Reset (rst, synchronous): registers return to 5000/500/4, all state clears.
module clock_pulse_width_statistics_unit #(
  parameter int CAPTURE_DEPTH = cpws_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cpws_pkg::in_item_t            in_data,
  // report output
  output logic                          out_valid,
  input  logic                          out_ready,
  output cpws_pkg::out_item_t           out_data,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpws_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  cpws_pkg::cfg_t   cfg;
  cpws_pkg::token_t push_token;
  cpws_pkg::token_t head_token;
  logic             accept;
  logic             push;
  logic             q_full;
  logic             q_not_empty;
  logic             pop;

  // a sample may close a pulse and report at once; it always fits in one entry
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  cpws_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpws_front #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_data),
    .cfg    (cfg),
    .push   (push),
    .token  (push_token)
  );

  cpws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_token),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head_token)
  );

  cpws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tok_valid (q_not_empty),
    .tok       (head_token),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/pulse_stats_monitor.sv
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts each report and
// compares it field by field against what the block returns.
module pulse_stats_monitor #(
  parameter int CAPTURE_DEPTH = cpws_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  cpws_pkg::in_item_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  cpws_pkg::out_item_t          out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [cpws_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fails,
  output int                           reports_due
);

  import cpws_pkg::*;

  cfg_t              cfg;
  logic              line_known;
  logic              last_level;
  logic              timing;
  int                sample_count;
  int                fall_index;
  int                run_length;
  int                edges_seen;
  logic [SKIP_W-1:0] high_skipped;
  logic [SKIP_W-1:0] low_skipped;
  stats_t            high_acc;
  stats_t            low_acc;
  out_item_t         pending_reports[$];
  int                report_no;

  task automatic clear_capture();
    line_known   = 1'b0;
    last_level   = 1'b0;
    timing       = 1'b0;
    sample_count = 0;
    fall_index   = 0;
    run_length   = 0;
    edges_seen   = 0;
    high_skipped = '0;
    low_skipped  = '0;
    high_acc     = STATS_RESET;
    low_acc      = STATS_RESET;
  endtask

  // Fold one closed pulse into the statistics of its level.
  task automatic fold_pulse(input logic was_high, input int w);
    stats_t            acc;
    logic [SKIP_W-1:0] skipped;
    int                sum;
    acc     = was_high ? high_acc : low_acc;
    skipped = was_high ? high_skipped : low_skipped;
    if (w == 0) return;
    if (skipped < cfg.skip_pulses) begin
      skipped = skipped + 1'b1;
    end else if (w < cfg.max_width) begin
      if (acc.count < COUNT_ONES) acc.count = acc.count + 1'b1;
      sum = acc.total + w;
      acc.total = (sum > TOTAL_ONES) ? TOTAL_ONES : sum[TOTAL_W-1:0];
      if (w < acc.min) acc.min = w[WIDTH_W-1:0];
      if (w > acc.max) acc.max = w[WIDTH_W-1:0];
    end
    if (was_high) begin
      high_acc     = acc;
      high_skipped = skipped;
    end else begin
      low_acc     = acc;
      low_skipped = skipped;
    end
  endtask

  task automatic take_level(input logic level);
    if (sample_count >= CAPTURE_DEPTH - 1) return;
    // first falling edge opens measurement
    if (!timing && line_known && last_level && !level) begin
      timing     = 1'b1;
      fall_index = sample_count;
      run_length = 0;
    end
    if (timing && edges_seen < cfg.max_transitions) begin
      if (level != last_level) begin
        edges_seen++;
        fold_pulse(last_level, run_length);
        run_length = 0;
      end
      if (run_length < WIDTH_ONES) run_length++;
    end
    last_level   = level;
    line_known   = 1'b1;
    sample_count++;
  endtask

  function automatic out_item_t build_report();
    out_item_t rep;
    rep.edge_found       = timing;
    rep.first_edge_index = timing ? fall_index[INDEX_W-1:0] : '0;
    rep.high_count       = high_acc.count;
    rep.high_total       = high_acc.total;
    rep.high_min         = high_acc.min;
    rep.high_max         = high_acc.max;
    rep.low_count        = low_acc.count;
    rep.low_total        = low_acc.total;
    rep.low_min          = low_acc.min;
    rep.low_max          = low_acc.max;
    return rep;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: report %0d %s expected %0d, got %0d", $time, report_no, name,
               want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.max_width       = MAX_WIDTH_RST;
      cfg.max_transitions = MAX_TRANSITIONS_RST;
      cfg.skip_pulses     = SKIP_PULSES_RST;
      clear_capture();
      pending_reports.delete();
      report_no = 0;
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_MAX_WIDTH:       cfg.max_width = pwdata[WIDTH_W-1:0];
          REG_MAX_TRANSITIONS: cfg.max_transitions = pwdata[COUNT_W-1:0];
          REG_SKIP_PULSES:     cfg.skip_pulses = pwdata[SKIP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_level(in_data.scl_level);
        if (in_data.end_of_capture) begin
          pending_reports.push_back(build_report());
          clear_capture();
        end
      end
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: report %0d expected none, got %h", $time, report_no, out_data);
          fails++;
        end else begin
          check_field("edge_found", pending_reports[0].edge_found, out_data.edge_found);
          check_field("first_edge_index", pending_reports[0].first_edge_index,
                      out_data.first_edge_index);
          check_field("high_count", pending_reports[0].high_count, out_data.high_count);
          check_field("high_total", pending_reports[0].high_total, out_data.high_total);
          check_field("high_min", pending_reports[0].high_min, out_data.high_min);
          check_field("high_max", pending_reports[0].high_max, out_data.high_max);
          check_field("low_count", pending_reports[0].low_count, out_data.low_count);
          check_field("low_total", pending_reports[0].low_total, out_data.low_total);
          check_field("low_min", pending_reports[0].low_min, out_data.low_min);
          check_field("low_max", pending_reports[0].low_max, out_data.low_max);
          void'(pending_reports.pop_front());
        end
        report_no++;
      end
    end
    reports_due <= pending_reports.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

// Top: clock, reset, sample and report traffic, register writes, verdict.
// All checking lives in pulse_stats_monitor.
module testbench;

  import cpws_pkg::*;

  // short sample window so one capture can run past it
  localparam int CAPTURE_DEPTH = 384;
  // long capture runs past the sample window
  localparam int LONG_LEN = CAPTURE_DEPTH + 16;
  // a random phase ends with the first capture that reaches this many samples
  localparam int PHASE_SAMPLES = 170;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fails;
  int                  reports_due;
  int                  send_burst = 0;   // samples left in a gap-free stretch
  int                  samples_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  clock_pulse_width_statistics_unit #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pulse_stats_monitor #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) stats_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fails       (fails),
    .reports_due (reports_due)
  );

  // One sample transaction. A random gap comes first, except inside a gap-free
  // stretch. in_valid stays high across back-to-back samples; it is only
  // dropped when a gap follows.
  task automatic send_sample(input logic level, input logic last);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      send_burst = $urandom_range(10, 80);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.scl_level <= level;
    in_data.end_of_capture <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  // Stop offering samples and wait for every outstanding report.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  // Setup cycle then access cycle; pready is tied high by the block.
  task automatic reg_write(input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Registers change only with the block idle: drain reports, then let the
  // internal queue (4 entries) empty of pulses that produce no report.
  task automatic configure(input int unsigned max_w, input int unsigned max_t,
                           input int unsigned skip);
    drain();
    repeat (10) @(posedge clk);
    reg_write(REG_MAX_WIDTH, max_w);
    reg_write(REG_MAX_TRANSITIONS, max_t);
    reg_write(REG_SKIP_PULSES, skip);
  endtask

  // Directed capture: pattern bits sent MSB first, last one ends the capture.
  task automatic send_levels(input logic [31:0] pattern, input int n);
    for (int i = n - 1; i >= 0; i--) send_sample(pattern[i], i == 0);
  endtask

  // Mostly short pulses, now and then a long one that trips max_width.
  function automatic int draw_run();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
  endfunction

  // One random capture: a run-structured clock line with random widths,
  // sometimes pure noise, sometimes only one to three samples.
  task automatic send_capture();
    int   len;
    int   run;
    logic level;
    logic noisy;
    noisy = ($urandom_range(0, 7) == 0);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
    level = $urandom_range(0, 1);
    run   = draw_run();
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        level = $urandom_range(0, 1);
      end else if (run == 0) begin
        level = ~level;
        run   = draw_run();
      end
      send_sample(level, i == len - 1);
      run--;
    end
  endtask

  // Report side: random ready gaps, gap-free stretches, and two long
  // hold-offs while the sender keeps going, so the queue fills and
  // in_ready drops.
  initial begin : take_reports
    int gap;
    int taken;
    int take_burst;
    out_ready <= 1'b0;
    taken = 0;
    take_burst = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 12 || taken == 30) begin
        gap = 600;
      end else if (take_burst > 0) begin
        take_burst--;
        gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        take_burst = $urandom_range(3, 10);
        gap = 0;
      end else begin
        gap = $urandom_range(0, 8);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : make_samples
    int   phase_start;
    int   run;
    logic level;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // single-sample captures: no previous level, so no edge either way
    send_levels(32'b1, 1);
    send_levels(32'b0, 1);
    // widest limits, no skip: a few short pulses, capture ends on an edge
    configure(WIDTH_ONES, COUNT_ONES, 0);
    send_levels(32'b0100111001, 10);
    // max_width 0 throws every pulse away
    configure(0, COUNT_ONES, 0);
    send_levels(32'b10110, 5);
    // max_transitions 0: first edge still reported, nothing measured
    configure(WIDTH_ONES, 0, 0);
    send_levels(32'b1010, 4);
    // tight limits: width 2 and up discarded, edge limit 3, skip one per level
    configure(2, 3, 1);
    send_levels(32'b1011001, 7);

    // --- long capture ---
    // A 200-sample low pulse, then short pulses run into the edge limit
    // and on past the sample window.
    configure(WIDTH_ONES, 40, 0);
    level = 1'b1;
    run   = 3;
    for (int i = 0; i < LONG_LEN; i++) begin
      if (run == 0) begin
        level = ~level;
        run   = (i == 3) ? 200 : $urandom_range(1, 5);
      end
      send_sample(level, i == LONG_LEN - 1);
      run--;
    end

    // --- random phases, one register setting each ---
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure($urandom_range(1, 12), COUNT_ONES, $urandom_range(0, 3));
        1: configure(WIDTH_ONES, $urandom_range(1, 30), {SKIP_W{1'b1}});
        2: configure(1, $urandom_range(1, COUNT_ONES), 0);
        3: configure($urandom_range(2, 40), $urandom_range(1, 8), $urandom_range(0, 15));
        4: configure($urandom_range(1, 12), $urandom_range(1, COUNT_ONES),
                     $urandom_range(0, 2));
        default: configure(MAX_WIDTH_RST, MAX_TRANSITIONS_RST, SKIP_PULSES_RST);
      endcase
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_SAMPLES) begin
        send_capture();
        // now and then let the report side catch up completely
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### clock_pulse_width_statistics_unit.f
src/cpws_pkg.sv
src/cpws_regs.sv
src/cpws_front.sv
src/cpws_queue.sv
src/cpws_back.sv
src/clock_pulse_width_statistics_unit.sv
bench/pulse_stats_monitor.sv
bench/testbench.sv
